FILE: rtl/scp_pkg.sv
// Shared types and constants for the servo command string parser.
package scp_pkg;

    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_P     = 8'h50;  // 'P'
    localparam logic [7:0] CH_T     = 8'h54;  // 'T'
    localparam logic [7:0] CH_BANG  = 8'h21;  // '!'
    localparam logic [7:0] CH_0     = 8'h30;  // '0'
    localparam logic [7:0] CH_9     = 8'h39;  // '9'
    localparam logic [7:0] CH_S     = 8'h53;  // 'S'
    localparam logic [7:0] CH_D     = 8'h44;  // 'D'
    localparam logic [7:0] CH_C     = 8'h43;  // 'C'
    localparam logic [7:0] CH_K     = 8'h4B;  // 'K'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'

    localparam logic [15:0] BIAS_MAX      = 16'd200;
    localparam logic [7:0]  SERVO_CNT_RST = 8'd8;
    localparam logic [3:0]  POS_SAT       = 4'd13;

    localparam logic [1:0] MATCH_BIAS = 2'b01;
    localparam logic [1:0] MATCH_STOP = 2'b10;

    typedef enum logic [1:0] {
        OP_MOVE = 2'd0,
        OP_STOP = 2'd1,
        OP_BIAS = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_SERVO = 4'b0010,
        MODE_PULSE = 4'b0100,
        MODE_TIME  = 4'b1000
    } field_mode_t;

    typedef struct packed {
        logic        hit;
        op_t         op;
        logic [15:0] servo_number;
        logic [13:0] bias;
        logic        scan_en;
    } fixed_res_t;

    typedef struct packed {
        logic        valid;
        logic [9:0]  number;
        logic [13:0] pulse;
        logic [13:0] duration;
    } move_t;

endpackage

FILE: rtl/scp_fixed_form.sv
// Fixed-position stop and bias form recognizer.
module scp_fixed_form
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              ch,
    input  logic                    last,
    input  logic [7:0]              servo_count,
    output scp_pkg::fixed_res_t     res
);

    logic [3:0]  pos_reg, pos_next;
    logic [1:0]  prefix_reg, prefix_next;
    logic [15:0] raw_number_reg, raw_number_next;
    logic [15:0] raw_bias_reg, raw_bias_next;
    logic [7:0]  bias_sign_reg, bias_sign_next;
    logic        skip_reg, skip_next;

    logic [15:0] d16;
    logic [15:0] raw_number_acc;
    logic [15:0] raw_bias_acc;
    logic [15:0] bias_neg;
    logic        bias_ok;

    assign d16            = {8'd0, ch} - {8'd0, scp_pkg::CH_0};
    assign raw_number_acc = 16'(raw_number_reg * 16'd10 + d16);
    assign raw_bias_acc   = 16'(raw_bias_reg * 16'd10 + d16);
    assign bias_neg       = 16'd0 - raw_bias_reg;
    assign bias_ok        = ($signed(raw_bias_reg) <= $signed(scp_pkg::BIAS_MAX))
                            && (raw_number_reg < {8'd0, servo_count});

    always_comb
    begin
        pos_next        = pos_reg;
        prefix_next     = prefix_reg;
        raw_number_next = raw_number_reg;
        raw_bias_next   = raw_bias_reg;
        bias_sign_next  = bias_sign_reg;
        skip_next       = skip_reg;

        res              = '0;
        res.op           = scp_pkg::OP_STOP;
        res.servo_number = raw_number_reg;
        res.scan_en      = !skip_reg;

        if (!skip_reg)
        begin
            case (pos_reg) inside
                4'd0:
                begin
                    prefix_next = (ch == scp_pkg::CH_HASH)
                                  ? (scp_pkg::MATCH_BIAS | scp_pkg::MATCH_STOP) : 2'b00;
                end
                [4'd1:4'd3]:
                begin
                    raw_number_next = raw_number_acc;
                end
                4'd4:
                begin
                    if (ch != scp_pkg::CH_P)
                        prefix_next = 2'b00;
                end
                4'd5:
                begin
                    if (ch != scp_pkg::CH_S) prefix_next = prefix_next & ~scp_pkg::MATCH_BIAS;
                    if (ch != scp_pkg::CH_D) prefix_next = prefix_next & ~scp_pkg::MATCH_STOP;
                end
                4'd6:
                begin
                    if (ch != scp_pkg::CH_C) prefix_next = prefix_next & ~scp_pkg::MATCH_BIAS;
                    if (ch != scp_pkg::CH_S) prefix_next = prefix_next & ~scp_pkg::MATCH_STOP;
                end
                4'd7:
                begin
                    if (ch != scp_pkg::CH_K) prefix_next = prefix_next & ~scp_pkg::MATCH_BIAS;
                    if (ch != scp_pkg::CH_T) prefix_next = prefix_next & ~scp_pkg::MATCH_STOP;
                end
                4'd8:
                begin
                    bias_sign_next = ch;
                    if (((prefix_reg & scp_pkg::MATCH_STOP) != 2'b00)
                        && ch == scp_pkg::CH_BANG)
                    begin
                        res.hit     = 1'b1;
                        res.scan_en = 1'b0;
                        skip_next   = 1'b1;
                    end
                end
                [4'd9:4'd11]:
                begin
                    raw_bias_next = raw_bias_acc;
                end
                4'd12:
                begin
                    if (((prefix_reg & scp_pkg::MATCH_BIAS) != 2'b00)
                        && ch == scp_pkg::CH_BANG && bias_ok)
                    begin
                        res.op = scp_pkg::OP_BIAS;
                        if (bias_sign_reg == scp_pkg::CH_PLUS)
                        begin
                            res.hit  = 1'b1;
                            res.bias = raw_bias_reg[13:0];
                        end
                        else if (bias_sign_reg == scp_pkg::CH_MINUS)
                        begin
                            res.hit  = 1'b1;
                            res.bias = bias_neg[13:0];
                        end
                    end
                end
                default:
                begin
                end
            endcase
            // stop form leaves position untouched; skip flag masks everything after
            if (!skip_next && pos_reg < scp_pkg::POS_SAT)
                pos_next = pos_reg + 4'd1;
        end

        if (last)
        begin
            pos_next        = '0;
            prefix_next     = scp_pkg::MATCH_BIAS | scp_pkg::MATCH_STOP;
            raw_number_next = '0;
            raw_bias_next   = '0;
            bias_sign_next  = '0;
            skip_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            prefix_reg     <= scp_pkg::MATCH_BIAS | scp_pkg::MATCH_STOP;
            raw_number_reg <= '0;
            raw_bias_reg   <= '0;
            bias_sign_reg  <= '0;
            skip_reg       <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg        <= pos_next;
            prefix_reg     <= prefix_next;
            raw_number_reg <= raw_number_next;
            raw_bias_reg   <= raw_bias_next;
            bias_sign_reg  <= bias_sign_next;
            skip_reg       <= skip_next;
        end
    end

endmodule

FILE: rtl/scp_field_scan.sv
// Running field scan: servo number, pulse and time accumulators.
module scp_field_scan
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              ch,
    input  logic                    last,
    input  logic                    scan_en,
    input  logic                    fixed_hit,
    output scp_pkg::move_t          move
);

    scp_pkg::field_mode_t mode_reg, mode_next;
    logic [1:0]  count_reg, count_next;
    logic [9:0]  number_reg, number_next;
    logic [13:0] pulse_reg, pulse_next;
    logic [13:0] time_reg, time_next;

    logic        is_digit;
    logic [3:0]  d;
    logic        field_done;

    assign is_digit = (ch >= scp_pkg::CH_0) && (ch <= scp_pkg::CH_9);
    assign d        = ch[3:0];
    assign field_done = (mode_reg == scp_pkg::MODE_SERVO) ? (count_reg == 2'd2)
                                                          : (count_reg == 2'd3);

    always_comb
    begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        number_next = number_reg;
        pulse_next  = pulse_reg;
        time_next   = time_reg;

        move.valid    = 1'b0;
        move.number   = number_reg;
        move.pulse    = pulse_reg;
        move.duration = 14'(time_reg * 14'd10 + 14'(d));

        if (scan_en)
        begin
            if (mode_reg != scp_pkg::MODE_IDLE)
            begin
                if (is_digit)
                begin
                    case (mode_reg)
                        scp_pkg::MODE_SERVO:
                            number_next = 10'(number_reg * 10'd10 + 10'(d));
                        scp_pkg::MODE_PULSE:
                            pulse_next  = 14'(pulse_reg * 14'd10 + 14'(d));
                        scp_pkg::MODE_TIME:
                            time_next   = move.duration;
                        default:
                        begin
                        end
                    endcase
                    if (field_done)
                    begin
                        move.valid = (mode_reg == scp_pkg::MODE_TIME) && !fixed_hit;
                        mode_next  = scp_pkg::MODE_IDLE;
                        count_next = 2'd0;
                    end
                    else
                    begin
                        count_next = count_reg + 2'd1;
                    end
                end
                else
                begin
                    mode_next  = scp_pkg::MODE_IDLE;
                    count_next = 2'd0;
                end
            end
            else
            begin
                case (ch)
                    scp_pkg::CH_HASH:
                    begin
                        number_next = '0;
                        mode_next   = scp_pkg::MODE_SERVO;
                        count_next  = 2'd0;
                    end
                    scp_pkg::CH_P:
                    begin
                        pulse_next = '0;
                        mode_next  = scp_pkg::MODE_PULSE;
                        count_next = 2'd0;
                    end
                    scp_pkg::CH_T:
                    begin
                        time_next  = '0;
                        mode_next  = scp_pkg::MODE_TIME;
                        count_next = 2'd0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (last)
        begin
            mode_next   = scp_pkg::MODE_IDLE;
            count_next  = '0;
            number_next = '0;
            pulse_next  = '0;
            time_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= scp_pkg::MODE_IDLE;
            count_reg  <= '0;
            number_reg <= '0;
            pulse_reg  <= '0;
            time_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            number_reg <= number_next;
            pulse_reg  <= pulse_next;
            time_reg   <= time_next;
        end
    end

endmodule

FILE: rtl/servo_command_string_parser_unit.sv
// Top level of the servo command string parser.
// A result word is registered: it is on the master side in the cycle after its character is accepted.
// Throughput: one character per cycle while the output is not stalled; state updates once per accepted character.
// The output register refills in the cycle it is taken, so input stalls only on output stall.
// Reset (rst_n, async, active low) clears parse state, output valid; servo_count returns to 8.
module servo_command_string_parser_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,      // servo_count
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] servo_number, [29:16] pulse,
                                        // [43:30] duration, [57:44] bias, [63:58] zero
    output logic [1:0]  m_axis_tuser    // [1:0] op
);

    logic [7:0]          servo_count_reg;
    logic                out_valid_reg;
    logic [63:0]         out_data_reg, out_data_next;
    logic [1:0]          out_op_reg, out_op_next;
    logic                accept;
    logic                result_valid;
    scp_pkg::fixed_res_t fixed_res;
    scp_pkg::move_t      move;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    scp_fixed_form u_fixed
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .ch          (s_axis_tdata),
        .last        (s_axis_tlast),
        .servo_count (servo_count_reg),
        .res         (fixed_res)
    );

    scp_field_scan u_scan
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .ch        (s_axis_tdata),
        .last      (s_axis_tlast),
        .scan_en   (fixed_res.scan_en),
        .fixed_hit (fixed_res.hit),
        .move      (move)
    );

    assign result_valid = fixed_res.hit || move.valid;

    always_comb
    begin
        if (fixed_res.hit)
        begin
            out_op_next   = fixed_res.op;
            out_data_next = {6'd0, fixed_res.bias, 14'd0, 14'd0, fixed_res.servo_number};
        end
        else
        begin
            out_op_next   = scp_pkg::OP_MOVE;
            out_data_next = {6'd0, 14'd0, move.duration, move.pulse, 6'd0, move.number};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_count_reg <= scp_pkg::SERVO_CNT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                servo_count_reg <= cfg_wdata;
            if (s_axis_tready)
                out_valid_reg <= accept && result_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && result_valid)
        begin
            out_data_reg <= out_data_next;
            out_op_reg   <= out_op_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_op_reg;

endmodule

FILE: rtl/scp_checker.sv
// Port-level checker for the servo command string parser, bound to the top level.
module scp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("output word without accepted character");

    a_op_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == scp_pkg::OP_MOVE
                           || m_axis_tuser == scp_pkg::OP_STOP
                           || m_axis_tuser == scp_pkg::OP_BIAS))
        else $error("illegal op code");

    a_fixed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != scp_pkg::OP_MOVE |-> m_axis_tdata[43:16] == 28'd0)
        else $error("pulse or duration nonzero on stop or bias");

endmodule

bind servo_command_string_parser_unit scp_checker u_scp_checker (.*);
